// ===== sv/stsm_pkg.sv =====
package stsm_pkg;

  localparam int MAX_SOURCES = 8;
  localparam int SRC_IDX_W   = $clog2(MAX_SOURCES);
  localparam int SRC_CNT_W   = $clog2(MAX_SOURCES + 1);
  localparam int LIST_DEPTH  = 256;
  localparam int LIST_IDX_W  = $clog2(LIST_DEPTH);
  localparam int LIST_CNT_W  = $clog2(LIST_DEPTH + 1);

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD_SRC = 2'd1,
    ACT_ADD_LIST = 2'd2,
    ACT_NEXT = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME = 3'd0,
    REG_DURATION = 3'd1,
    REG_IVL_ENABLE = 3'd2,
    REG_IVL_FIRST = 3'd3,
    REG_IVL_STEP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] first_or_value;
    logic [30:0] period;
  } in_item_t;

  typedef struct packed {
    logic [31:0] tick;
    logic        tick_valid;
    logic        exhausted;
    logic        every_state;
    logic        table_full;
  } out_item_t;

endpackage

// ===== sv/save_tick_schedule_merge_unit.sv =====
// Save-tick schedule merge. A command is accepted when start is high and busy
// is low. Clear and add commands answer in the next cycle without raising busy.
// A next command reads the source table twice, one entry per cycle (a minimum
// pass, then an update pass that writes back advanced offsets), with busy held
// high; the update pass is skipped when every series is used up, and with no
// loaded sources only the final merge step runs. The result strobe comes in the
// first cycle with busy low again. Every command yields exactly one result,
// shown for one cycle on out_valid; the receiver cannot stall it.
module save_tick_schedule_merge_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  stsm_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output stsm_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stsm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import stsm_pkg::*;

  typedef struct packed {
    logic [30:0] src_begin;
    logic [30:0] src_period;
    logic [31:0] src_offset;
  } src_ent_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  // configuration
  logic [30:0] start_time_r, duration_r, ivl_first_r, ivl_step_r;
  logic        ivl_enable_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
      duration_r   <= '0;
      ivl_enable_r <= 1'b0;
      ivl_first_r  <= '0;
      ivl_step_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_TIME: start_time_r <= pwdata[30:0];
        REG_DURATION:   duration_r   <= pwdata[30:0];
        REG_IVL_ENABLE: ivl_enable_r <= pwdata[0];
        REG_IVL_FIRST:  ivl_first_r  <= pwdata[30:0];
        REG_IVL_STEP:   ivl_step_r   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START_TIME: prdata = {1'b0, start_time_r};
      REG_DURATION:   prdata = {1'b0, duration_r};
      REG_IVL_ENABLE: prdata = {31'd0, ivl_enable_r};
      REG_IVL_FIRST:  prdata = {1'b0, ivl_first_r};
      REG_IVL_STEP:   prdata = {1'b0, ivl_step_r};
      default:        prdata = '0;
    endcase
  end

  // memories
  src_ent_t              src_mem [MAX_SOURCES];
  src_ent_t              src_rdata_r;
  logic [SRC_IDX_W-1:0]  src_raddr, src_waddr;
  logic                  src_we;
  src_ent_t              src_wdata;

  logic [30:0]           list_mem [LIST_DEPTH];
  logic [30:0]           list_rdata_r;
  logic                  list_we;

  // control
  state_t                state_r, state_nxt;
  logic [SRC_CNT_W-1:0]  src_count_r, src_count_nxt;
  logic [LIST_CNT_W-1:0] list_count_r, list_count_nxt;
  logic [LIST_CNT_W-1:0] list_read_r, list_read_nxt;
  logic [31:0]           ivl_next_r, ivl_next_nxt;
  logic [SRC_IDX_W-1:0]  k_r, k_nxt;
  logic [31:0]           best_r, best_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic        accept, ivl_on, k_last;
  logic [32:0] src_sum;
  logic        src_live;
  logic [31:0] src_head;
  logic        list_live, ivl_live;
  logic [31:0] list_head, ivl_head, fin_best;
  logic [32:0] ivl_sum;
  logic        fin_found;
  logic [30:0] add_period;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign ivl_on   = ivl_enable_r && (ivl_step_r != '0);
  assign k_last   = ({1'b0, k_r} == src_count_r - SRC_CNT_W'(1));

  assign src_sum  = {2'b0, src_rdata_r.src_begin} + {1'b0, src_rdata_r.src_offset};
  assign src_live = (src_sum <= {2'b0, duration_r});
  assign src_head = {1'b0, start_time_r} + src_sum[31:0];

  assign list_live = (list_read_r < list_count_r) && (list_rdata_r <= duration_r);
  assign list_head = {1'b0, start_time_r} + {1'b0, list_rdata_r};
  assign ivl_sum   = {2'b0, ivl_first_r} + {1'b0, ivl_next_r};
  assign ivl_live  = ivl_on && (ivl_sum <= {2'b0, duration_r});
  assign ivl_head  = ivl_sum[31:0];

  assign add_period = (in_data.period == '0) ? 31'd1 : in_data.period;

  always_comb begin
    fin_best  = best_r;
    fin_found = found_r;
    if (list_live && (!fin_found || list_head < fin_best)) begin
      fin_best  = list_head;
      fin_found = 1'b1;
    end
    if (ivl_live && (!fin_found || ivl_head < fin_best)) begin
      fin_best  = ivl_head;
      fin_found = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    src_count_nxt  = src_count_r;
    list_count_nxt = list_count_r;
    list_read_nxt  = list_read_r;
    ivl_next_nxt   = ivl_next_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    src_raddr      = '0;
    src_we         = 1'b0;
    src_waddr      = k_r;
    src_wdata      = src_rdata_r;
    list_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          unique case (action_t'(in_data.action))
            ACT_CLEAR: begin
              src_count_nxt  = '0;
              list_count_nxt = '0;
              list_read_nxt  = '0;
              ivl_next_nxt   = '0;
              out_valid_nxt  = 1'b1;
            end
            ACT_ADD_SRC: begin
              out_valid_nxt = 1'b1;
              if (src_count_r >= SRC_CNT_W'(MAX_SOURCES)) begin
                out_data_nxt.table_full = 1'b1;
              end else begin
                src_we               = 1'b1;
                src_waddr            = src_count_r[SRC_IDX_W-1:0];
                src_wdata.src_begin  = in_data.first_or_value;
                src_wdata.src_period = add_period;
                src_wdata.src_offset = (in_data.first_or_value == '0) ?
                                       {1'b0, add_period} : 32'd0;
                src_count_nxt        = src_count_r + SRC_CNT_W'(1);
              end
            end
            ACT_ADD_LIST: begin
              out_valid_nxt = 1'b1;
              if (list_count_r >= LIST_CNT_W'(LIST_DEPTH)) begin
                out_data_nxt.table_full = 1'b1;
              end else begin
                list_we        = 1'b1;
                list_count_nxt = list_count_r + LIST_CNT_W'(1);
              end
            end
            ACT_NEXT: begin
              if (src_count_r == '0 && list_count_r == '0 && !ivl_on) begin
                out_valid_nxt            = 1'b1;
                out_data_nxt.every_state = 1'b1;
              end else begin
                best_nxt  = '0;
                found_nxt = 1'b0;
                k_nxt     = '0;
                state_nxt = (src_count_r == '0) ? S_FIN : S_MIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_MIN: begin
        // entry k_r is on the read port
        if (src_live && (!found_r || src_head < best_r)) begin
          best_nxt  = src_head;
          found_nxt = 1'b1;
        end
        if (k_last) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + SRC_IDX_W'(1);
          src_raddr = k_r + SRC_IDX_W'(1);
        end
      end
      S_FIN: begin
        best_nxt = fin_best;
        k_nxt    = '0;
        if (!fin_found) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.exhausted = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          if (list_live && list_head == fin_best) begin
            list_read_nxt = list_read_r + LIST_CNT_W'(1);
          end
          if (ivl_live && ivl_head == fin_best) begin
            ivl_next_nxt = ivl_next_r + {1'b0, ivl_step_r};
          end
          out_data_nxt.tick       = fin_best;
          out_data_nxt.tick_valid = 1'b1;
          if (src_count_r == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        // write back entry k_r while k_r+1 is read
        if (src_live && src_head == best_r) begin
          src_we               = 1'b1;
          src_wdata.src_offset = src_rdata_r.src_offset + {1'b0, src_rdata_r.src_period};
        end
        if (k_last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = k_r + SRC_IDX_W'(1);
          src_raddr = k_r + SRC_IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_count_r  <= '0;
      list_count_r <= '0;
      list_read_r  <= '0;
      ivl_next_r   <= '0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      src_count_r  <= src_count_nxt;
      list_count_r <= list_count_nxt;
      list_read_r  <= list_read_nxt;
      ivl_next_r   <= ivl_next_nxt;
      out_valid_r  <= out_valid_nxt;
      k_r          <= k_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= src_wdata;
    src_rdata_r <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_count_r[LIST_IDX_W-1:0]] <= in_data.first_or_value;
    list_rdata_r <= list_mem[list_read_r[LIST_IDX_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/stsm_checker.sv =====
module stsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input stsm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input stsm_pkg::out_item_t out_data
);
  import stsm_pkg::*;

  // table commands answer on the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action != ACT_NEXT) |=> out_valid)
    else $error("clear or add did not answer in one cycle");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.tick_valid, out_data.exhausted,
                            out_data.every_state, out_data.table_full}))
    else $error("result carries more than one status");

  a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tick_valid) |-> (out_data.tick == 32'd0))
    else $error("tick nonzero without tick_valid");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_busy_falls_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result transfer");

endmodule

bind save_tick_schedule_merge_unit stsm_checker u_stsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
